/* rtl/clup_pkg.sv */
// Shared constants, types and mixing functions of the chroma line-pair upsampler.
package clup_pkg;

   localparam int SAMPLE_W               = 8;
   localparam int LINE_WIDTH_W           = 15;
   localparam int DEFAULT_MAX_LINE_WIDTH = 16384;

   // APB register file: one 32-bit register, word addressed
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_SEL_W  = CSR_ADDR_W - 2;
   localparam logic [CSR_SEL_W-1:0] CSR_LINE_WIDTH = '0;
   localparam logic [LINE_WIDTH_W-1:0] LINE_WIDTH_RESET = LINE_WIDTH_W'(1);

   // front-to-back queue
   localparam int QUEUE_DEPTH = 2;

   typedef logic [SAMPLE_W-1:0] sample_type;

   // One classified column, as handed from the front to the back
   typedef struct packed {
      sample_type cur_pu;    // upper row U, this column
      sample_type cur_cu;    // lower row U, this column
      sample_type cur_pv;
      sample_type cur_cv;
      sample_type held_pu;   // previous column
      sample_type held_cu;
      sample_type held_pv;
      sample_type held_cv;
      logic       first;     // column 0: edge rule only
      logic       last;      // last column of the line
      logic       tail;      // even width: extra edge position at the end
   } clup_entry_type;

   // (3n + f + 2) >> 2
   function automatic sample_type edge_mix(input sample_type n, input sample_type f);
      logic [SAMPLE_W+1:0] acc;
      acc = ((SAMPLE_W+2)'(n) << 1) + (SAMPLE_W+2)'(n) + (SAMPLE_W+2)'(f)
            + (SAMPLE_W+2)'(2);
      return acc[SAMPLE_W+1:2];
   endfunction

   // (9n + 3h + 3v + d + 8) >> 4
   function automatic sample_type fancy_mix(input sample_type n, input sample_type h,
                                            input sample_type v, input sample_type d);
      logic [SAMPLE_W+3:0] acc;
      logic [SAMPLE_W+3:0] hv;
      hv  = (SAMPLE_W+4)'(h) + (SAMPLE_W+4)'(v);
      acc = ((SAMPLE_W+4)'(n) << 3) + (SAMPLE_W+4)'(n) + (hv << 1) + hv
            + (SAMPLE_W+4)'(d) + (SAMPLE_W+4)'(8);
      return acc[SAMPLE_W+3:4];
   endfunction

endpackage

/* rtl/clup_if.sv */
// Valid/ready channel interfaces for column items and upsampled pixel results.
interface clup_req_if;
   import clup_pkg::*;
   logic       valid;
   logic       ready;
   sample_type prev_row_u;
   sample_type cur_row_u;
   sample_type prev_row_v;
   sample_type cur_row_v;

   modport source (output valid, prev_row_u, cur_row_u, prev_row_v, cur_row_v,
                   input ready);
   modport sink   (input valid, prev_row_u, cur_row_u, prev_row_v, cur_row_v,
                   output ready);
endinterface

interface clup_rsp_if;
   import clup_pkg::*;
   logic       valid;
   logic       ready;
   sample_type upper_u;
   sample_type upper_v;
   sample_type lower_u;
   sample_type lower_v;
   logic       end_of_line;

   modport source (output valid, upper_u, upper_v, lower_u, lower_v, end_of_line,
                   input ready);
   modport sink   (input valid, upper_u, upper_v, lower_u, lower_v, end_of_line,
                    output ready);
endinterface

/* rtl/clup_front.sv */
// Front end: register file, column tracking and classification of each column.
module clup_front #(
   parameter int MAX_LINE_WIDTH = clup_pkg::DEFAULT_MAX_LINE_WIDTH
) (
   input  logic                            clock,
   input  logic                            reset,
   clup_req_if.sink                        req_chan,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [clup_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [clup_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [clup_pkg::CSR_DATA_W-1:0] prdata,
   output logic                            push_valid,
   output clup_pkg::clup_entry_type        push_entry,
   input  logic                            push_ready
);
   import clup_pkg::*;

   localparam int COL_W = $clog2((MAX_LINE_WIDTH + 1) / 2 + 1);

   logic [LINE_WIDTH_W-1:0] line_width_ff, line_width_in;
   logic [COL_W-1:0]        col_ff, col_in;
   sample_type              held_pu_ff, held_cu_ff, held_pv_ff, held_cv_ff;
   logic [LINE_WIDTH_W-1:0] eff_width;
   logic [LINE_WIDTH_W-1:0] last_col;
   logic                    csr_hit, csr_wr, accept, is_last, is_even;

   assign csr_hit = (paddr[CSR_ADDR_W-1:2] == CSR_LINE_WIDTH);
   assign csr_wr  = psel && penable && pwrite && csr_hit;
   assign prdata  = csr_hit ? CSR_DATA_W'(line_width_ff) : '0;

   // zero acts as one, oversized widths clamp
   always_comb begin
      priority if (line_width_ff == '0) begin
         eff_width = LINE_WIDTH_W'(1);
      end else if (32'(line_width_ff) > 32'(MAX_LINE_WIDTH)) begin
         eff_width = LINE_WIDTH_W'(MAX_LINE_WIDTH);
      end else begin
         eff_width = line_width_ff;
      end
   end

   assign last_col = (eff_width - LINE_WIDTH_W'(1)) >> 1;
   assign is_last  = 32'(col_ff) >= 32'(last_col);
   assign is_even  = !eff_width[0];

   assign req_chan.ready = push_ready;
   assign accept         = req_chan.valid && push_ready;
   assign push_valid     = req_chan.valid;

   always_comb begin
      push_entry.cur_pu  = req_chan.prev_row_u;
      push_entry.cur_cu  = req_chan.cur_row_u;
      push_entry.cur_pv  = req_chan.prev_row_v;
      push_entry.cur_cv  = req_chan.cur_row_v;
      push_entry.held_pu = held_pu_ff;
      push_entry.held_cu = held_cu_ff;
      push_entry.held_pv = held_pv_ff;
      push_entry.held_cv = held_cv_ff;
      push_entry.first   = (col_ff == '0);
      push_entry.last    = is_last;
      push_entry.tail    = is_last && is_even;
   end

   always_comb begin
      line_width_in = line_width_ff;
      col_in        = col_ff;
      if (csr_wr) begin
         line_width_in = pwdata[LINE_WIDTH_W-1:0];
         col_in        = '0;
      end else if (accept) begin
         col_in = is_last ? '0 : col_ff + COL_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_width_ff <= LINE_WIDTH_RESET;
         col_ff        <= '0;
         held_pu_ff    <= '0;
         held_cu_ff    <= '0;
         held_pv_ff    <= '0;
         held_cv_ff    <= '0;
      end else begin
         line_width_ff <= line_width_in;
         col_ff        <= col_in;
         if (accept) begin
            held_pu_ff <= req_chan.prev_row_u;
            held_cu_ff <= req_chan.cur_row_u;
            held_pv_ff <= req_chan.prev_row_v;
            held_cv_ff <= req_chan.cur_row_v;
         end
      end
   end

endmodule

/* rtl/clup_queue.sv */
// Short FIFO of classified columns between the front and the back.
module clup_queue (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push_valid,
   input  clup_pkg::clup_entry_type push_entry,
   output logic                     push_ready,
   output logic                     pop_valid,
   output clup_pkg::clup_entry_type pop_entry,
   input  logic                     pop_ready
);
   import clup_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(QUEUE_DEPTH - 1);

   clup_entry_type   slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign push_ready = (count_ff != CNT_W'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_entry  = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == LAST_SLOT) ? '0 : wr_ptr_ff + PTR_W'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == LAST_SLOT) ? '0 : rd_ptr_ff + PTR_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

/* rtl/clup_back.sv */
// Back end: expands each column into its luma positions, one per cycle while rsp_chan does not stall it.
module clup_back (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     pop_valid,
   input  clup_pkg::clup_entry_type pop_entry,
   output logic                     pop_ready,
   clup_rsp_if.source               rsp_chan
);
   import clup_pkg::*;

   typedef enum logic [1:0] {
      KIND_EDGE,
      KIND_ODD,
      KIND_EVEN
   } kind_type;

   logic [1:0] phase_ff, last_phase;
   kind_type   kind;
   logic       load, final_phase;
   sample_type uu, uv, lu, lv;
   logic       rsp_valid_ff;
   sample_type upper_u_ff, upper_v_ff, lower_u_ff, lower_v_ff;
   logic       eol_ff;

   assign last_phase  = (pop_entry.first ? 2'd0 : 2'd1) + (pop_entry.tail ? 2'd1 : 2'd0);
   assign final_phase = (phase_ff == last_phase);
   assign load        = !rsp_valid_ff || rsp_chan.ready;
   assign pop_ready   = load && final_phase;

   always_comb begin
      priority if (pop_entry.first) begin
         kind = KIND_EDGE;
      end else if (phase_ff == 2'd0) begin
         kind = KIND_ODD;
      end else if (phase_ff == 2'd1) begin
         kind = KIND_EVEN;
      end else begin
         kind = KIND_EDGE;
      end
   end

   always_comb begin
      unique case (kind)
         KIND_ODD: begin
            uu = fancy_mix(pop_entry.held_pu, pop_entry.cur_pu, pop_entry.held_cu,
                           pop_entry.cur_cu);
            uv = fancy_mix(pop_entry.held_pv, pop_entry.cur_pv, pop_entry.held_cv,
                           pop_entry.cur_cv);
            lu = fancy_mix(pop_entry.held_cu, pop_entry.cur_cu, pop_entry.held_pu,
                           pop_entry.cur_pu);
            lv = fancy_mix(pop_entry.held_cv, pop_entry.cur_cv, pop_entry.held_pv,
                           pop_entry.cur_pv);
         end
         KIND_EVEN: begin
            uu = fancy_mix(pop_entry.cur_pu, pop_entry.held_pu, pop_entry.cur_cu,
                           pop_entry.held_cu);
            uv = fancy_mix(pop_entry.cur_pv, pop_entry.held_pv, pop_entry.cur_cv,
                           pop_entry.held_cv);
            lu = fancy_mix(pop_entry.cur_cu, pop_entry.held_cu, pop_entry.cur_pu,
                           pop_entry.held_pu);
            lv = fancy_mix(pop_entry.cur_cv, pop_entry.held_cv, pop_entry.cur_pv,
                           pop_entry.held_pv);
         end
         default: begin
            uu = edge_mix(pop_entry.cur_pu, pop_entry.cur_cu);
            uv = edge_mix(pop_entry.cur_pv, pop_entry.cur_cv);
            lu = edge_mix(pop_entry.cur_cu, pop_entry.cur_pu);
            lv = edge_mix(pop_entry.cur_cv, pop_entry.cur_pv);
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (load) begin
         rsp_valid_ff <= pop_valid;
         if (pop_valid) begin
            phase_ff <= final_phase ? 2'd0 : phase_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load && pop_valid) begin
         upper_u_ff <= uu;
         upper_v_ff <= uv;
         lower_u_ff <= lu;
         lower_v_ff <= lv;
         eol_ff     <= final_phase && pop_entry.last;
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.upper_u     = upper_u_ff;
   assign rsp_chan.upper_v     = upper_v_ff;
   assign rsp_chan.lower_u     = lower_u_ff;
   assign rsp_chan.lower_v     = lower_v_ff;
   assign rsp_chan.end_of_line = eol_ff;

endmodule

/* rtl/chroma_line_pair_upsampler.sv */
// Top level of the chroma line-pair upsampler (9-3-3-1 fancy chroma upsampling).
//
// One transaction on req_chan carries one chroma column (U and V of the upper
// and lower chroma rows); rsp_chan returns one transaction per luma position,
// with U/V for both luma rows and end_of_line on the line's last position.
// Column 0 yields one position, every later column two, and on an even line
// width the last column adds one more edge position. The back end emits one
// result per cycle from an output register while rsp_chan does not stall it,
// one per luma position of the column; the sustained rate is set by the output
// channel at one luma position per cycle. A two-entry queue sits between the
// front end and the back end, so new columns can still be accepted while a
// result waits on rsp_chan, until the queue is full. An accepted column is
// written into the queue; its first result is computed from the queue head,
// registered in the output register and then offered on rsp_chan.
// line_width lives at byte address 0 of the APB port
// (reset value 1; zero acts as one, values above MAX_LINE_WIDTH clamp);
// writing it restarts the line and must only happen while the block is idle.
module chroma_line_pair_upsampler #(
   parameter int MAX_LINE_WIDTH = clup_pkg::DEFAULT_MAX_LINE_WIDTH
) (
   input  logic                            clock,
   input  logic                            reset,
   clup_req_if.sink                        req_chan,
   clup_rsp_if.source                      rsp_chan,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [clup_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [clup_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [clup_pkg::CSR_DATA_W-1:0] prdata,
   output logic                            pready
);
   import clup_pkg::*;

   // front -> queue
   logic           push_valid, push_ready;
   clup_entry_type push_entry;
   // queue -> back
   logic           pop_valid, pop_ready;
   clup_entry_type pop_entry;

   // register writes complete in the access phase, no wait states
   assign pready = 1'b1;

   // classification: first/last column, even-width tail, previous column
   clup_front #(
      .MAX_LINE_WIDTH (MAX_LINE_WIDTH)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .psel       (psel),
      .penable    (penable),
      .pwrite     (pwrite),
      .paddr      (paddr),
      .pwdata     (pwdata),
      .prdata     (prdata),
      .push_valid (push_valid),
      .push_entry (push_entry),
      .push_ready (push_ready)
   );

   clup_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_entry (push_entry),
      .push_ready (push_ready),
      .pop_valid  (pop_valid),
      .pop_entry  (pop_entry),
      .pop_ready  (pop_ready)
   );

   // expansion into luma positions and output register
   clup_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_entry (pop_entry),
      .pop_ready (pop_ready),
      .rsp_chan  (rsp_chan)
   );

endmodule
